// ----- hdl/assert_macros.svh -----
// Assertion helpers, clocked on i_clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked during reset too
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/kwm_pkg.sv -----
`default_nettype none
package kwm_pkg;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_START = 1'b1;

    localparam int VAL_W = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_FILL,
        S_SCAN,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

// ----- hdl/kwm_store.sv -----
`default_nettype none
module kwm_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_wr_en,
    input  wire logic [ADDR_W-1:0]         i_wr_addr,
    input  wire logic [kwm_pkg::VAL_W-1:0] i_wr_data,
    input  wire logic                      i_rd_en,
    input  wire logic [ADDR_W-1:0]         i_rd_addr,
    output logic      [kwm_pkg::VAL_W-1:0] o_rd_data
);
    import kwm_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ----- hdl/k_way_sorted_merge.sv -----
// Channel | Direction | Handshake               | Word
// --------+-----------+-------------------------+---------------------------------------
// in      | input     | i_in_valid / o_in_stall | i_action, i_list_number, i_element_value
// out     | output    | o_out_valid / i_out_stall | o_merged_value, o_is_last
//
// o_in_stall stays low in idle, where load words are accepted.
// A start word seeds one head per list.
// For each merged word, one shared signed comparator scans the list heads, the
// winner is emitted, then one store read refills it if its list has more.
// Reset (i_rst_n low, synchronous) empties all lists; the store is not cleared.
// A stall on the output, while a word is pending there, holds the sequencer at the emit step.
`default_nettype none
module k_way_sorted_merge #(
    parameter int NUM_LISTS  = 4,
    parameter int LIST_DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_action,
    input  wire logic [1:0]                       i_list_number,
    input  wire logic signed [kwm_pkg::VAL_W-1:0] i_element_value,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic signed [kwm_pkg::VAL_W-1:0]      o_merged_value,
    output logic                                  o_is_last
);
    import kwm_pkg::*;

`include "assert_macros.svh"

    localparam int LW     = $clog2(NUM_LISTS);
    localparam int POS_W  = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int ADDR_W = LW + IDX_W;
    localparam int DEPTH  = NUM_LISTS * (2 ** IDX_W);
    localparam logic [LW-1:0]    LAST_K = LW'(NUM_LISTS - 1);
    localparam logic [POS_W-1:0] FULL   = POS_W'(LIST_DEPTH);

    t_state r_state, n_state;

    logic [LW-1:0]           r_k;
    logic                    r_seed;
    logic                    r_best_vld;
    logic [LW-1:0]           r_best;
    logic signed [VAL_W-1:0] r_best_val;
    logic [POS_W-1:0]        r_fill  [NUM_LISTS];
    logic [POS_W-1:0]        r_rdpos [NUM_LISTS];
    logic signed [VAL_W-1:0] r_head  [NUM_LISTS];
    logic [NUM_LISTS-1:0]    r_head_vld;
    logic                    r_out_vld;
    logic signed [VAL_W-1:0] r_out_val;
    logic                    r_out_last;

    logic                 w_in_acc;
    logic                 w_load;
    logic                 w_start;
    logic                 w_lst_ok;
    logic [LW-1:0]        w_lst;
    logic                 w_wr_en;
    logic [ADDR_W-1:0]    w_wr_addr;
    logic                 w_rd_en;
    logic [ADDR_W-1:0]    w_rd_addr;
    logic [VAL_W-1:0]     w_rd_data;
    logic [NUM_LISTS-1:0] w_more;
    logic [NUM_LISTS-1:0] w_k_hot;
    logic                 w_take;
    logic                 w_found;
    logic                 w_out_free;
    logic                 w_last;
    logic                 w_seed_next;

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_load   = w_in_acc && (i_action == ACT_LOAD);
    assign w_start  = w_in_acc && (i_action == ACT_START);
    assign w_lst_ok = int'(i_list_number) < NUM_LISTS;
    assign w_lst    = LW'(i_list_number);

    always_comb begin
        for (int j = 0; j < NUM_LISTS; j++) begin
            w_more[j]  = r_rdpos[j] < r_fill[j];
            w_k_hot[j] = (r_k == LW'(j));
        end
    end

    // shared compare: strict less keeps the lower list on ties
    assign w_take = r_head_vld[r_k] && (!r_best_vld || (r_head[r_k] < r_best_val));
    assign w_found     = r_best_vld || w_take;
    assign w_out_free  = !r_out_vld || !i_out_stall;
    assign w_last      = ((r_head_vld & ~w_k_hot) == '0) && !w_more[r_k];
    assign w_seed_next = r_seed && (r_k != LAST_K);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_start) n_state = S_FETCH;
            end
            S_FETCH: begin
                if (w_more[r_k]) n_state = S_FILL;
                else if (w_seed_next) n_state = S_FETCH;
                else n_state = S_SCAN;
            end
            S_FILL: begin
                n_state = w_seed_next ? S_FETCH : S_SCAN;
            end
            S_SCAN: begin
                if (r_k == LAST_K) n_state = w_found ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (w_out_free) n_state = w_last ? S_IDLE : S_FETCH;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_wr_en    = 1'b0;
        w_rd_en    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                w_wr_en    = w_load && w_lst_ok && (r_fill[w_lst] != FULL);
            end
            S_FETCH: w_rd_en = w_more[r_k];
            S_FILL:  w_rd_en = 1'b0;
            S_SCAN:  w_rd_en = 1'b0;
            S_EMIT:  w_rd_en = 1'b0;
            default: w_rd_en = 1'b0;
        endcase
    end

    assign w_wr_addr = {w_lst, r_fill[w_lst][IDX_W-1:0]};
    assign w_rd_addr = {r_k, r_rdpos[r_k][IDX_W-1:0]};

    kwm_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_element_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_k        <= '0;
            r_seed     <= 1'b0;
            r_best_vld <= 1'b0;
            r_best     <= '0;
            r_head_vld <= '0;
            r_out_vld  <= 1'b0;
            for (int j = 0; j < NUM_LISTS; j++) begin
                r_fill[j]  <= '0;
                r_rdpos[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_EMIT && w_out_free) r_out_vld <= 1'b1;
            else if (r_out_vld && !i_out_stall) r_out_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_wr_en) r_fill[w_lst] <= r_fill[w_lst] + 1'b1;
                    if (w_start) begin
                        r_k    <= '0;
                        r_seed <= 1'b1;
                        for (int j = 0; j < NUM_LISTS; j++) r_rdpos[j] <= '0;
                    end
                end
                S_FETCH: begin
                    if (!w_more[r_k]) begin
                        r_head_vld[r_k] <= 1'b0;
                        if (w_seed_next) begin
                            r_k <= r_k + 1'b1;
                        end else begin
                            r_k        <= '0;
                            r_best_vld <= 1'b0;
                        end
                    end
                end
                S_FILL: begin
                    r_head[r_k]     <= w_rd_data;
                    r_head_vld[r_k] <= 1'b1;
                    r_rdpos[r_k]    <= r_rdpos[r_k] + 1'b1;
                    if (w_seed_next) begin
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_k        <= '0;
                        r_best_vld <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (w_take) begin
                        r_best_vld <= 1'b1;
                        r_best     <= r_k;
                        r_best_val <= r_head[r_k];
                    end
                    if (r_k == LAST_K) begin
                        r_k <= w_take ? r_k : r_best;
                        if (!w_found) begin
                            for (int j = 0; j < NUM_LISTS; j++) begin
                                r_fill[j]  <= '0;
                                r_rdpos[j] <= '0;
                            end
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_val       <= r_best_val;
                        r_out_last      <= w_last;
                        r_seed          <= 1'b0;
                        // on the last word this was the only valid head
                        r_head_vld[r_k] <= 1'b0;
                        if (w_last) begin
                            for (int j = 0; j < NUM_LISTS; j++) begin
                                r_fill[j]  <= '0;
                                r_rdpos[j] <= '0;
                            end
                        end
                    end
                end
                default: r_k <= '0;
            endcase
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_merged_value = r_out_val;
    assign o_is_last      = r_out_last;

    `ASSERT_CLK(a_emit_holds, (r_state == S_EMIT && r_out_vld && i_out_stall) |=> (r_state == S_EMIT), "emit step left while output stalled")
    `ASSERT_CLK(a_last_ends, (r_state == S_EMIT && w_out_free && w_last) |=> (r_state == S_IDLE && r_head_vld == '0), "merge did not end after last word")
    `ASSERT_CLK(a_fill_after_fetch, (r_state == S_FILL) |-> ($past(r_state) == S_FETCH), "head fill without store read")
    `ASSERT_CLK(a_rdpos_bound, (r_state == S_FETCH) |-> (r_rdpos[r_k] <= r_fill[r_k]), "read position passed fill count")
    `ASSERT_ALWAYS(a_reset_idle, (!i_rst_n) |=> (r_state == S_IDLE && !r_out_vld), "reset did not clear control")

endmodule
`default_nettype wire

// ----- test/k_way_sorted_merge_tb.sv -----
`default_nettype none
module k_way_sorted_merge_tb;
    import kwm_pkg::*;

    localparam int NUM_LISTS  = 4;
    localparam int LIST_DEPTH = 16;
    localparam int ITEM_GOAL  = 420;
    localparam int IDLE_LIMIT = 3000;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_merged_word;

    class merge_scoreboard;
        logic signed [VAL_W-1:0] list_store [NUM_LISTS][LIST_DEPTH];
        int unsigned             list_fill [NUM_LISTS];
        t_merged_word            merged_q[$];
        int                      mismatches;

        function new();
            mismatches = 0;
            foreach (list_fill[l]) list_fill[l] = 0;
        endfunction

        function int pending_count();
            return merged_q.size();
        endfunction

        // load appends to a list; start merges all heads, lowest list wins ties
        function void note_word(logic act, logic [1:0] list_no,
                                logic signed [VAL_W-1:0] value);
            int unsigned  head [NUM_LISTS];
            int           total;
            int           best;
            t_merged_word w;
            if (act == ACT_LOAD) begin
                if (int'(list_no) < NUM_LISTS && list_fill[list_no] < LIST_DEPTH) begin
                    list_store[list_no][list_fill[list_no]] = value;
                    list_fill[list_no]++;
                end
                return;
            end
            total = 0;
            foreach (head[l]) begin
                head[l] = 0;
                total += list_fill[l];
            end
            for (int n = 0; n < total; n++) begin
                best = -1;
                for (int l = 0; l < NUM_LISTS; l++) begin
                    if (head[l] < list_fill[l]) begin
                        if (best < 0 || list_store[l][head[l]] < list_store[best][head[best]])
                            best = l;
                    end
                end
                w.value = list_store[best][head[best]];
                w.last  = (n == total - 1);
                head[best]++;
                merged_q.insert(merged_q.size(), w);
            end
            foreach (list_fill[l]) list_fill[l] = 0;
        endfunction

        function void check_word(logic signed [VAL_W-1:0] value, logic last);
            t_merged_word want;
            if (merged_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected merged word %0d is_last %0b", value, last);
                return;
            end
            want = merged_q.pop_front();
            if (value !== want.value) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("merged_value: expected %0d got %0d", want.value, value);
            end
            if (last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("is_last: expected %0b got %0b (value %0d)",
                             want.last, last, want.value);
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_action = ACT_LOAD;
    logic [1:0]              i_list_number = 2'd0;
    logic signed [VAL_W-1:0] i_element_value = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [VAL_W-1:0] o_merged_value;
    logic                    o_is_last;

    merge_scoreboard sb;
    int              items_sent = 0;
    bit              no_gaps = 1'b0;
    int              stall_left = 0;
    int              idle_cycles = 0;

    k_way_sorted_merge #(
        .NUM_LISTS (NUM_LISTS),
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_list_number  (i_list_number),
        .i_element_value(i_element_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_merged_value (o_merged_value),
        .o_is_last      (o_is_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // result side: random stall after each accepted word, none while no_gaps is set
    always @(posedge i_clk) begin
        int w;
        w = stall_left;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_word(o_merged_value, o_is_last);
                w = no_gaps ? 0 : $urandom_range(0, 6);
            end else if (w > 0) begin
                w--;
            end
        end
        stall_left  = w;
        i_out_stall <= (w != 0);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("FAIL k_way_sorted_merge");
        $finish;
    end

    task automatic send_word(input logic act, input logic [1:0] list_no,
                             input logic signed [VAL_W-1:0] value);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_list_number   <= list_no;
        i_element_value <= value;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        sb.note_word(act, list_no, value);
        items_sent++;
    endtask

    task automatic drain_merges();
        while (sb.pending_count() != 0) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // random lists, mostly ascending with ties; scrambled sets are unsorted noise
    task automatic load_and_merge(input bit scrambled);
        logic signed [VAL_W-1:0] lane_q [NUM_LISTS][$];
        logic signed [VAL_W-1:0] v;
        int                      cnt;
        int                      roll;
        int                      pick;
        int                      left;
        left = 0;
        for (int l = 0; l < NUM_LISTS; l++) begin
            roll = $urandom_range(0, 19);
            cnt = (roll < 4)  ? 0 :
                  (roll < 16) ? $urandom_range(1, 5) :
                  (roll < 19) ? $urandom_range(6, LIST_DEPTH) :
                                $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 4);
            v = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40) - 20;
            repeat (cnt) begin
                lane_q[l].insert(lane_q[l].size(), scrambled ? $urandom : v);
                v = v + $urandom_range(0, 3);
            end
            left += cnt;
        end
        while (left > 0) begin
            pick = $urandom_range(0, NUM_LISTS - 1);
            if (lane_q[pick].size() != 0) begin
                send_word(ACT_LOAD, pick[1:0], lane_q[pick].pop_front());
                left--;
            end
        end
        send_word(ACT_START, 2'($urandom_range(0, 3)), $urandom);
    endtask

    initial begin
        int set_no;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // start with nothing loaded
        send_word(ACT_START, 2'd0, 32'sd0);
        // value extremes, an unsorted list, an empty list, a tie and a full list
        send_word(ACT_LOAD, 2'd0, 32'sh8000_0000);
        send_word(ACT_LOAD, 2'd1, 32'sh7fff_ffff);
        send_word(ACT_LOAD, 2'd0, 32'sd0);
        send_word(ACT_LOAD, 2'd1, -32'sd1);
        for (int i = 0; i <= LIST_DEPTH; i++)
            send_word(ACT_LOAD, 2'd3, i - 8);
        send_word(ACT_START, 2'd3, 32'shffff_ffff);

        set_no = 0;
        while (items_sent < ITEM_GOAL) begin
            if ($urandom_range(0, 3) == 0)
                no_gaps = ~no_gaps;
            load_and_merge($urandom_range(0, 9) == 0);
            if (set_no == 2 || $urandom_range(0, 4) == 0)
                drain_merges();
            set_no++;
        end

        i_in_valid <= 1'b0;
        no_gaps = 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (4 * NUM_LISTS + 20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_count() == 0)
            $display("PASS k_way_sorted_merge");
        else
            $display("FAIL k_way_sorted_merge");
        $finish;
    end
endmodule
`default_nettype wire

// ----- k_way_sorted_merge.f -----
+incdir+hdl
hdl/kwm_pkg.sv
hdl/kwm_store.sv
hdl/k_way_sorted_merge.sv
test/k_way_sorted_merge_tb.sv
